FILE: rtl/angle_proportional_slew_limiter_assert.svh
`ifndef ANGLE_PROPORTIONAL_SLEW_LIMITER_ASSERT_SVH
`define ANGLE_PROPORTIONAL_SLEW_LIMITER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define APSL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("apsl same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define APSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("apsl next-cycle check failed");

`endif

FILE: rtl/apsl_pkg.sv
package apsl_pkg;

  localparam int DATA_W    = 16;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_CNT_W = $clog2(DATA_W);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP      = 2'd2;

  localparam logic [CFG_W-1:0] RST_DIVISOR_SCALE = 15'd1;
  localparam logic [CFG_W-1:0] RST_MAX_STEP      = 15'h7fff;
  localparam logic [CFG_W-1:0] RST_MIN_STEP      = 15'd0;

  // Operation codes of an input request.
  localparam logic OP_STEP = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [CFG_W-1:0]  divisor;
  } div_req_t;

endpackage

FILE: rtl/apsl_in_if.sv
interface apsl_in_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic signed [apsl_pkg::DATA_W-1:0] target;

  modport source (output valid, output op, output target, input ready);
  modport sink   (input valid, input op, input target, output ready);
endinterface

FILE: rtl/apsl_out_if.sv
interface apsl_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [apsl_pkg::DATA_W-1:0] new_value;
  logic signed [apsl_pkg::DATA_W-1:0] remaining_diff;

  modport source (output valid, output new_value, output remaining_diff, input ready);
  modport sink   (input valid, input new_value, input remaining_diff, output ready);
endinterface

FILE: rtl/apsl_cfg_if.sv
interface apsl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [apsl_pkg::CFG_IDX_W-1:0]   idx;
  logic [apsl_pkg::CFG_W-1:0]       data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

FILE: rtl/apsl_div.sv
`include "angle_proportional_slew_limiter_assert.svh"

// Restoring unsigned divider, one quotient bit per cycle.
module apsl_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  apsl_pkg::div_req_t            req,
  output logic                          done,
  output logic [apsl_pkg::DATA_W-1:0]   quot
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [apsl_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [apsl_pkg::CFG_W-1:0]      rem_r, rem_nxt;
  logic [apsl_pkg::CFG_W-1:0]      dvs_r, dvs_nxt;
  logic [apsl_pkg::DATA_W-1:0]     quo_r, quo_nxt;
  logic [apsl_pkg::DATA_W-1:0]     trial;
  logic [apsl_pkg::DATA_W-1:0]     trial_sub;
  logic                            fits;

  // The dividend shifts out of the top of quo_r while quotient bits enter below.
  always_comb begin
    trial     = {rem_r, quo_r[apsl_pkg::DATA_W-1]};
    fits      = trial >= {1'b0, dvs_r};
    trial_sub = trial - {1'b0, dvs_r};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? trial_sub[apsl_pkg::CFG_W-1:0] : trial[apsl_pkg::CFG_W-1:0];
      quo_nxt = {quo_r[apsl_pkg::DATA_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == apsl_pkg::DIV_CNT_W'(apsl_pkg::DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

  `APSL_ASSERT_SAME(a_div_done_idle, clk, rst_n, done_r, !busy_r)
  `APSL_ASSERT_NEXT(a_div_start_busy, clk, rst_n, req.start, busy_r && !done_r)
  `APSL_ASSERT_SAME(a_div_rem_below, clk, rst_n, busy_r, rem_r < dvs_r)

endmodule

FILE: rtl/angle_proportional_slew_limiter.sv
// Angle proportional slew limiter. The block keeps a 16-bit wrapping value
// (a binary angle, for instance) and moves it toward the target of each step
// request by the wrapped difference divided by divisor_scale, clamped to
// max_step, or by min_step when the proportional step is not larger than
// min_step, snapping onto the target when min_step reaches or passes it. A
// load request sets the value directly and reports a difference of zero.
// Every request yields exactly one result carrying the new value and the
// wrapped difference seen before the step. Requests are handled one at a
// time: in_ch.ready is high only while the sequencer is idle. A step request
// is accepted, launches the restoring divider, which produces one quotient
// bit per cycle, waits for it to finish, applies the step, checks the snap,
// and hands the result to the output register. A load request, or a step
// whose target equals the current value, goes from acceptance straight to
// the hand-off. The output register frees the sequencer from a stalled
// consumer: a finished result waits there while the next request is already
// being worked on. Configuration writes are always ready and must only be
// issued while no request is in flight; a divisor_scale of zero divides
// by one.

`include "angle_proportional_slew_limiter_assert.svh"

module angle_proportional_slew_limiter (
  input  logic       clk,
  input  logic       rst_n,
  apsl_in_if.sink    in_ch,
  apsl_out_if.source out_ch,
  apsl_cfg_if.sink   cfg_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_APPLY,
    S_SNAP,
    S_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [apsl_pkg::CFG_W-1:0]   scale_r, scale_nxt;
  logic [apsl_pkg::CFG_W-1:0]   max_r, max_nxt;
  logic [apsl_pkg::CFG_W-1:0]   min_r, min_nxt;
  logic [apsl_pkg::DATA_W-1:0]  cur_r, cur_nxt;
  logic [apsl_pkg::DATA_W-1:0]  tgt_r, tgt_nxt;
  logic [apsl_pkg::DATA_W-1:0]  diff_r, diff_nxt;
  logic [apsl_pkg::DATA_W-1:0]  nv_r, nv_nxt;
  logic                         use_min_r, use_min_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [apsl_pkg::DATA_W-1:0]  out_value_r, out_value_nxt;
  logic [apsl_pkg::DATA_W-1:0]  out_diff_r, out_diff_nxt;

  apsl_pkg::div_req_t           div_req;
  logic                         div_done;
  logic [apsl_pkg::DATA_W-1:0]  div_quot;

  logic                         in_fire;
  logic                         cfg_fire;
  logic [apsl_pkg::DATA_W-1:0]  in_diff;
  logic                         diff_neg;
  logic [apsl_pkg::DATA_W-1:0]  step_mag;
  logic [apsl_pkg::DATA_W-1:0]  prop_mag;
  logic [apsl_pkg::DATA_W-1:0]  left_diff;
  logic                         snap;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign diff_neg = diff_r[apsl_pkg::DATA_W-1];

  // Wrapped difference of the incoming target against the held value.
  assign in_diff = in_ch.target - cur_r;

  // The divider works on magnitudes; the sign of the difference is reapplied
  // when the step is added.
  always_comb begin
    div_req.start    = (state_r == S_START);
    div_req.dividend = diff_neg ? (~diff_r + 1'b1) : diff_r;
    div_req.divisor  = (scale_r == '0) ? apsl_pkg::CFG_W'(1) : scale_r;
  end

  apsl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  // The proportional step is clamped to max_step in magnitude.
  assign prop_mag = (div_quot > {1'b0, max_r}) ? {1'b0, max_r} : div_quot;

  // Snap test: after a min_step move the target must not be ahead any more.
  assign left_diff = tgt_r - nv_r;
  assign snap = use_min_r &&
                (diff_neg ? !left_diff[apsl_pkg::DATA_W-1]
                          : (left_diff[apsl_pkg::DATA_W-1] || (left_diff == '0)));

  always_comb begin
    state_nxt     = state_r;
    scale_nxt     = scale_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    cur_nxt       = cur_r;
    tgt_nxt       = tgt_r;
    diff_nxt      = diff_r;
    nv_nxt        = nv_r;
    use_min_nxt   = use_min_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_value_nxt = out_value_r;
    out_diff_nxt  = out_diff_r;
    step_mag      = '0;

    if (cfg_fire) begin
      case (cfg_ch.idx)
        apsl_pkg::CFG_DIVISOR_SCALE: scale_nxt = cfg_ch.data;
        apsl_pkg::CFG_MAX_STEP:      max_nxt   = cfg_ch.data;
        apsl_pkg::CFG_MIN_STEP:      min_nxt   = cfg_ch.data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          tgt_nxt = in_ch.target;
          if (in_ch.op == apsl_pkg::OP_LOAD) begin
            cur_nxt   = in_ch.target;
            diff_nxt  = '0;
            state_nxt = S_DONE;
          end else begin
            diff_nxt  = in_diff;
            state_nxt = (in_diff == '0) ? S_DONE : S_START;
          end
        end
      end
      S_START: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        // A proportional step larger than min_step wins; otherwise min_step.
        if (div_quot > {1'b0, min_r}) begin
          step_mag    = prop_mag;
          use_min_nxt = 1'b0;
        end else begin
          step_mag    = {1'b0, min_r};
          use_min_nxt = 1'b1;
        end
        nv_nxt    = diff_neg ? (cur_r - step_mag) : (cur_r + step_mag);
        state_nxt = S_SNAP;
      end
      S_SNAP: begin
        cur_nxt   = snap ? tgt_r : nv_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = cur_r;
          out_diff_nxt  = diff_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scale_r     <= apsl_pkg::RST_DIVISOR_SCALE;
      max_r       <= apsl_pkg::RST_MAX_STEP;
      min_r       <= apsl_pkg::RST_MIN_STEP;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scale_r     <= scale_nxt;
      max_r       <= max_nxt;
      min_r       <= min_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tgt_r       <= tgt_nxt;
    diff_r      <= diff_nxt;
    nv_r        <= nv_nxt;
    use_min_r   <= use_min_nxt;
    out_value_r <= out_value_nxt;
    out_diff_r  <= out_diff_nxt;
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign cfg_ch.ready          = 1'b1;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.new_value      = out_value_r;
  assign out_ch.remaining_diff = out_diff_r;

  `APSL_ASSERT_SAME(a_done_only_in_div, clk, rst_n, div_done, state_r == S_DIV)
  `APSL_ASSERT_NEXT(a_load_sets_value, clk, rst_n, in_fire && (in_ch.op == apsl_pkg::OP_LOAD), (cur_r == $past(in_ch.target)) && (state_r == S_DONE))
  `APSL_ASSERT_NEXT(a_prop_no_snap, clk, rst_n, (state_r == S_SNAP) && !use_min_r, cur_r == $past(nv_r))
  `APSL_ASSERT_NEXT(a_done_to_idle, clk, rst_n, (state_r == S_DONE) && !out_valid_r, out_valid_r && (state_r == S_IDLE))

endmodule

FILE: tb/tb_angle_proportional_slew_limiter.sv
// Checks the angle slew limiter against a cycle-free model of its arithmetic.
// Every accepted request is run through the model at once, and the result it
// predicts is queued. Every result taken from the block is compared field by
// field with the oldest queued prediction.

module tb_angle_proportional_slew_limiter;

  // The configuration port decodes two index bits, but only three registers
  // exist. Writes to the fourth index must leave the block unchanged.
  localparam logic [apsl_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  localparam int MAX_FIELD    = 32767;
  localparam int PHASE_ITEMS  = 97;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 30;
  localparam int HOLD_OFF_LEN = 250;

  typedef struct packed {
    logic [apsl_pkg::DATA_W-1:0] new_value;
    logic [apsl_pkg::DATA_W-1:0] remaining_diff;
  } slew_move_t;

  logic clk;
  logic rst_n;

  apsl_in_if  in_bus();
  apsl_out_if out_bus();
  apsl_cfg_if cfg_bus();

  angle_proportional_slew_limiter DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus),
    .cfg_ch(cfg_bus)
  );

  // Model state. It changes only when the block accepts a request or a
  // register write, so it always describes the block as seen from outside.
  logic [apsl_pkg::DATA_W-1:0] cur_angle;
  logic [apsl_pkg::CFG_W-1:0]  scale_reg;
  logic [apsl_pkg::CFG_W-1:0]  max_reg;
  logic [apsl_pkg::CFG_W-1:0]  min_reg;

  // Results predicted for accepted requests that have not come out yet.
  slew_move_t predicted_moves[$];

  int errors;
  int cycle_count;
  int n_requests;
  int n_loads;
  int n_on_target;
  int n_snaps;
  int n_results;
  int n_cfg_writes;
  int stall_run;
  int longest_in_stall;

  // When set, neither side inserts any idle cycles.
  bit steady;

  // The test sequence asks for a long output hold-off by bumping the tag.
  // The result sink notices the new tag and counts the hold-off down itself.
  int hold_off_len;
  int hold_off_tag;
  int hold_off_served;
  int hold_left;
  int sink_wait;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Gap lengths: mostly back to back or short, now and then a long one that
  // outlasts the whole division of a step request.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Applies one request to the model state and returns the result the block
  // must produce for it.
  function automatic slew_move_t advance_angle(logic op,
                                               logic [apsl_pkg::DATA_W-1:0] tgt);
    slew_move_t                         move;
    logic signed [apsl_pkg::DATA_W-1:0] gap;
    logic signed [apsl_pkg::DATA_W-1:0] gap_after;
    int                                 divisor;
    int                                 quot;
    int                                 lo;
    int                                 hi;
    gap = '0;
    if (op == apsl_pkg::OP_LOAD) begin
      cur_angle = tgt;
      n_loads++;
    end else begin
      // The difference wraps around the circle, so it is the short way
      // round, as a signed 16-bit number.
      gap = tgt - cur_angle;
      if (cur_angle == tgt) begin
        n_on_target++;
      end else begin
        divisor = (scale_reg == '0) ? 1 : int'(scale_reg);
        quot    = int'(gap) / divisor;
        lo      = int'(min_reg);
        hi      = int'(max_reg);
        if (quot > lo || quot < -lo) begin
          // The proportional step wins, limited to the maximum step.
          if (quot > hi) quot = hi;
          if (quot < -hi) quot = -hi;
          cur_angle = cur_angle + quot[apsl_pkg::DATA_W-1:0];
        end else if (gap >= 0) begin
          // A fixed minimum step forward, snapping onto the target if the
          // step reached or crossed it.
          cur_angle = cur_angle + {1'b0, min_reg};
          gap_after = tgt - cur_angle;
          if (gap_after <= 0) begin
            cur_angle = tgt;
            n_snaps++;
          end
        end else begin
          cur_angle = cur_angle - {1'b0, min_reg};
          gap_after = tgt - cur_angle;
          if (gap_after >= 0) begin
            cur_angle = tgt;
            n_snaps++;
          end
        end
      end
    end
    move.new_value      = cur_angle;
    move.remaining_diff = gap;
    return move;
  endfunction

  // Targets are drawn near the current angle, near the opposite side of the
  // circle, at the field extremes, or anywhere at all.
  function automatic logic [apsl_pkg::DATA_W-1:0] pick_target();
    logic [apsl_pkg::DATA_W-1:0] offset;
    offset = apsl_pkg::DATA_W'($urandom_range(0, 64)) - apsl_pkg::DATA_W'(32);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      1, 2, 3: return cur_angle + offset;
      4: return cur_angle + 16'h8000 + offset;
      default: return apsl_pkg::DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [apsl_pkg::CFG_W-1:0] pick_reg_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return apsl_pkg::CFG_W'(MAX_FIELD);
      2: return apsl_pkg::CFG_W'(1);
      3: return apsl_pkg::CFG_W'($urandom_range(2, 16));
      default: return apsl_pkg::CFG_W'($urandom);
    endcase
  endfunction

  // Watches all three channels at the rising edge. A request updates the
  // model and queues its prediction; a result is checked against the oldest
  // prediction.
  always @(posedge clk) begin
    slew_move_t want;
    if (rst_n) begin
      if (in_bus.valid && !in_bus.ready) begin
        stall_run++;
        if (stall_run > longest_in_stall) longest_in_stall = stall_run;
      end else begin
        stall_run = 0;
      end

      if (in_bus.valid && in_bus.ready) begin
        predicted_moves.push_back(advance_angle(in_bus.op, in_bus.target));
        n_requests++;
      end

      if (cfg_bus.valid && cfg_bus.ready) begin
        n_cfg_writes++;
        case (cfg_bus.idx)
          apsl_pkg::CFG_DIVISOR_SCALE: scale_reg = cfg_bus.data;
          apsl_pkg::CFG_MAX_STEP:      max_reg   = cfg_bus.data;
          apsl_pkg::CFG_MIN_STEP:      min_reg   = cfg_bus.data;
          default: ;
        endcase
      end

      if (out_bus.valid && out_bus.ready) begin
        n_results++;
        if (predicted_moves.size() == 0) begin
          errors++;
          $display("%0t: result with no request pending: new_value %0d remaining_diff %0d",
                   $time, out_bus.new_value, out_bus.remaining_diff);
        end else begin
          want = predicted_moves.pop_front();
          if (out_bus.new_value !== want.new_value) begin
            errors++;
            $display("%0t: new_value expected %0d, got %0d",
                     $time, $signed(want.new_value), out_bus.new_value);
          end
          if (out_bus.remaining_diff !== want.remaining_diff) begin
            errors++;
            $display("%0t: remaining_diff expected %0d, got %0d",
                     $time, $signed(want.remaining_diff), out_bus.remaining_diff);
          end
        end
      end
    end
  end

  // Result sink. It alternates ready runs and stall runs of random length,
  // holds ready high throughout a steady stretch, and serves a requested
  // long hold-off by counting it down here.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      sink_wait     <= 0;
      hold_left     <= 0;
    end else if (hold_off_tag != hold_off_served) begin
      hold_off_served <= hold_off_tag;
      hold_left       <= hold_off_len;
      out_bus.ready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      if (hold_left == 1) out_bus.ready <= 1'b1;
    end else if (steady) begin
      out_bus.ready <= 1'b1;
    end else if (sink_wait > 0) begin
      sink_wait <= sink_wait - 1;
    end else if (out_bus.ready) begin
      out_bus.ready <= 1'b0;
      sink_wait     <= pick_gap();
    end else begin
      out_bus.ready <= 1'b1;
      sink_wait     <= $urandom_range(0, 12);
    end
  end

  // A stuck handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time,
               predicted_moves.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offers one request and returns once the block has taken it. With a zero
  // gap valid stays high so the next request follows immediately.
  task automatic send_request(input logic op, input logic [apsl_pkg::DATA_W-1:0] tgt);
    int gap;
    gap = steady ? 0 : pick_gap();
    @(negedge clk);
    in_bus.valid  <= 1'b1;
    in_bus.op     <= op;
    in_bus.target <= tgt;
    do @(posedge clk); while (!in_bus.ready);
    if (gap > 0) begin
      @(negedge clk) in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Waits until every predicted result has come out and the block has had
  // time to finish any bookkeeping, so a register can be written safely.
  task automatic drain_results();
    @(negedge clk) in_bus.valid <= 1'b0;
    while (predicted_moves.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [apsl_pkg::CFG_IDX_W-1:0] reg_idx,
                                input logic [apsl_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.idx   <= reg_idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk) cfg_bus.valid <= 1'b0;
  endtask

  task automatic write_settings(input logic [apsl_pkg::CFG_W-1:0] scale_v,
                                input logic [apsl_pkg::CFG_W-1:0] max_v,
                                input logic [apsl_pkg::CFG_W-1:0] min_v);
    drain_results();
    write_register(apsl_pkg::CFG_DIVISOR_SCALE, scale_v);
    write_register(apsl_pkg::CFG_MAX_STEP, max_v);
    write_register(apsl_pkg::CFG_MIN_STEP, min_v);
  endtask

  // Reset settings move the full distance in one step, except across a half
  // circle difference, which max_step clamps; also covers a request already
  // on target and loads at the extremes of the angle.
  task automatic test_reset_state();
    send_request(apsl_pkg::OP_STEP, 16'h0000);
    send_request(apsl_pkg::OP_STEP, 16'h7fff);
    send_request(apsl_pkg::OP_STEP, 16'h8000);
    send_request(apsl_pkg::OP_STEP, 16'h0000);
    send_request(apsl_pkg::OP_LOAD, 16'h8000);
    send_request(apsl_pkg::OP_STEP, 16'h8000);
    send_request(apsl_pkg::OP_LOAD, 16'h7fff);
    send_request(apsl_pkg::OP_LOAD, 16'hffff);
  endtask

  // A divisor of zero must behave like a divisor of one.
  task automatic test_divisor_zero();
    write_settings('0, apsl_pkg::CFG_W'(MAX_FIELD), '0);
    send_request(apsl_pkg::OP_STEP, 16'h0101);
    send_request(apsl_pkg::OP_STEP, 16'h8000);
  endtask

  // The minimum step in all its forms: no movement when both the
  // proportional step and the minimum are zero, a maximal minimum step that
  // snaps or stops short, and a modest minimum step snapping either way.
  task automatic test_min_step_cases();
    write_settings(apsl_pkg::CFG_W'(MAX_FIELD), apsl_pkg::CFG_W'(MAX_FIELD), '0);
    send_request(apsl_pkg::OP_LOAD, 16'h0000);
    send_request(apsl_pkg::OP_STEP, 16'h0064);
    write_settings(apsl_pkg::CFG_W'(MAX_FIELD), apsl_pkg::CFG_W'(MAX_FIELD),
                   apsl_pkg::CFG_W'(MAX_FIELD));
    send_request(apsl_pkg::OP_LOAD, 16'h0000);
    send_request(apsl_pkg::OP_STEP, 16'h0010);
    send_request(apsl_pkg::OP_LOAD, 16'h0000);
    send_request(apsl_pkg::OP_STEP, 16'h8000);
    send_request(apsl_pkg::OP_STEP, 16'hfffb);
    write_settings(apsl_pkg::CFG_W'(1), apsl_pkg::CFG_W'(MAX_FIELD), apsl_pkg::CFG_W'(100));
    send_request(apsl_pkg::OP_LOAD, 16'h0000);
    send_request(apsl_pkg::OP_STEP, 16'h0032);
    send_request(apsl_pkg::OP_STEP, 16'hffff);
  endtask

  // A maximum step of zero freezes proportional movement; a small one
  // limits it.
  task automatic test_max_step_limit();
    write_settings(apsl_pkg::CFG_W'(1), '0, '0);
    send_request(apsl_pkg::OP_STEP, 16'h1234);
    write_settings(apsl_pkg::CFG_W'(1), apsl_pkg::CFG_W'(5), '0);
    send_request(apsl_pkg::OP_STEP, 16'h1234);
  endtask

  // A write to the unused index must not disturb any register.
  task automatic test_unused_register();
    drain_results();
    write_register(CFG_UNUSED_IDX, apsl_pkg::CFG_W'($urandom));
    send_request(apsl_pkg::OP_STEP, pick_target());
  endtask

  // The sink stops taking results for a long stretch while requests keep
  // coming, so the output register fills and the input backs up.
  task automatic test_output_backpressure();
    write_settings(apsl_pkg::CFG_W'($urandom_range(1, 8)), pick_reg_value(),
                   apsl_pkg::CFG_W'($urandom_range(0, 40)));
    @(posedge clk);
    hold_off_len = HOLD_OFF_LEN;
    hold_off_tag++;
    repeat (10) send_request(apsl_pkg::OP_STEP, pick_target());
  endtask

  // Back-to-back requests with the sink always ready.
  task automatic test_unbroken_stream();
    steady = 1'b1;
    repeat (40) begin
      send_request(($urandom_range(0, 7) == 0) ? apsl_pkg::OP_LOAD : apsl_pkg::OP_STEP,
                   pick_target());
    end
    steady = 1'b0;
  endtask

  // Several register settings, the extremes first. Most traffic is runs of
  // steps chasing one target, so the value converges and snaps; loads and
  // single jumps are mixed in.
  task automatic test_random_settings();
    logic [apsl_pkg::DATA_W-1:0] goal;
    int                          sent;
    int                          run;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_settings(apsl_pkg::CFG_W'(1), apsl_pkg::CFG_W'(MAX_FIELD), '0);
        1: write_settings(apsl_pkg::CFG_W'(MAX_FIELD), '0, apsl_pkg::CFG_W'(MAX_FIELD));
        2: write_settings('0, apsl_pkg::CFG_W'(MAX_FIELD), apsl_pkg::CFG_W'(MAX_FIELD));
        3: write_settings(apsl_pkg::CFG_W'(4), apsl_pkg::CFG_W'(300), apsl_pkg::CFG_W'(20));
        default: write_settings(pick_reg_value(), pick_reg_value(), pick_reg_value());
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0) begin
          send_request(apsl_pkg::OP_LOAD, apsl_pkg::DATA_W'($urandom));
          sent++;
        end else begin
          goal = pick_target();
          run  = $urandom_range(1, 12);
          repeat (run) begin
            send_request(apsl_pkg::OP_STEP, goal);
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    // Scoreboard and model start from the reset state of the block.
    errors           = 0;
    cycle_count      = 0;
    n_requests       = 0;
    n_loads          = 0;
    n_on_target      = 0;
    n_snaps          = 0;
    n_results        = 0;
    n_cfg_writes     = 0;
    stall_run        = 0;
    longest_in_stall = 0;
    steady           = 1'b0;
    hold_off_len     = 0;
    hold_off_tag     = 0;
    hold_off_served  = 0;
    cur_angle        = '0;
    scale_reg        = apsl_pkg::RST_DIVISOR_SCALE;
    max_reg          = apsl_pkg::RST_MAX_STEP;
    min_reg          = apsl_pkg::RST_MIN_STEP;

    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.op      = apsl_pkg::OP_STEP;
    in_bus.target  = '0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.idx    = apsl_pkg::CFG_DIVISOR_SCALE;
    cfg_bus.data   = '0;
    out_bus.ready  = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_reset_state();
    test_divisor_zero();
    test_min_step_cases();
    test_max_step_limit();
    test_unused_register();
    test_output_backpressure();
    test_unbroken_stream();
    test_random_settings();

    // Let the last results drain, then watch a while for stray output.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_moves.size() != 0) errors++;

    $display("Run covered %0d requests (%0d loads, %0d on target, %0d snaps) and %0d results,",
             n_requests, n_loads, n_on_target, n_snaps, n_results);
    $display("with %0d register writes and input stalls of up to %0d cycles.",
             n_cfg_writes, longest_in_stall);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
